FILE: rtl/fpbs_pkg.sv
// shared types and constants for the frequency/phase budget scheduler
// no dependencies; imported by every module of the block
package fpbs_pkg;

    // default sizing
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 32;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int PERIOD_W  = 16;
    localparam int PHASE_W   = 16;
    localparam int TIME_W    = 32;
    localparam int FRAME_W   = 32;
    localparam int BUDGET_W  = 40;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 4;
    localparam int PENDING_W = 6;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 56;

    // budget loaded after reset: 3.5 ms in nanoseconds
    localparam logic [TIME_W-1:0] FRAME_BUDGET_RESET = 32'd3500000;

    // most negative budget value
    localparam logic [BUDGET_W-1:0] BUDGET_MIN = {1'b1, {(BUDGET_W-1){1'b0}}};

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DONE = 2'd2;

    // classified command
    typedef enum logic [1:0] {
        OP_ADD,
        OP_TICK,
        OP_DONE,
        OP_NONE
    } op_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED      = 2'd0,
        KIND_REJECTED   = 2'd1,
        KIND_DISPATCH   = 2'd2,
        KIND_FRAME_OVER = 2'd3
    } kind_t;

    // command handed from front to back; operand is worst time or elapsed time
    typedef struct packed {
        op_t                 op;
        logic [PERIOD_W-1:0] period;
        logic [PHASE_W-1:0]  phase;
        logic [TIME_W-1:0]   operand;
    } cmd_t;

    // one result item
    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   entry_index;
        logic                 queue_overflow;
        logic [BUDGET_W-1:0]  budget_left;
        logic [PENDING_W-1:0] pending_count;
    } result_t;

endpackage

FILE: rtl/fpbs_front.sv
// front end: accepts input items, classifies the action and queues commands
// depends on fpbs_pkg
module fpbs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [fpbs_pkg::ACTION_W-1:0] in_action,
    input  logic [fpbs_pkg::S_TDATA_W-1:0] in_data,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output fpbs_pkg::cmd_t        cmd
);
    import fpbs_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       new_cmd;
    logic       push;
    logic       pop;

    // classify the action and pick the time operand
    always_comb
    begin
        new_cmd.period = in_data[15:0];
        new_cmd.phase  = in_data[31:16];
        unique case (in_action)
            ACT_ADD:
            begin
                new_cmd.op      = OP_ADD;
                new_cmd.operand = in_data[63:32];
            end
            ACT_TICK:
            begin
                new_cmd.op      = OP_TICK;
                new_cmd.operand = in_data[95:64];
            end
            ACT_DONE:
            begin
                new_cmd.op      = OP_DONE;
                new_cmd.operand = in_data[95:64];
            end
            default:
            begin
                new_cmd.op      = OP_NONE;
                new_cmd.operand = in_data[95:64];
            end
        endcase
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // two-entry command queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: rtl/fpbs_mod_unit.sv
// bit-serial remainder unit: (frame + phase) mod period, one bit a cycle
// depends on fpbs_pkg
module fpbs_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fpbs_pkg::FRAME_W:0]    dividend,
    input  logic [fpbs_pkg::PERIOD_W-1:0] divisor,
    output logic                          done,
    output logic [fpbs_pkg::PERIOD_W-1:0] remainder
);
    import fpbs_pkg::*;

    localparam int DVD_W = FRAME_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [PERIOD_W:0]   rem_reg;
    logic [PERIOD_W:0]   rem_next;
    logic [PERIOD_W:0]   shifted;
    logic [DVD_W-1:0]    dvd_reg;
    logic [PERIOD_W-1:0] div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg[PERIOD_W-1:0], dvd_reg[DVD_W-1]};
        if (shifted >= {1'b0, div_reg})
        begin
            rem_next = shifted - {1'b0, div_reg};
        end
        else
        begin
            rem_next = shifted;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[PERIOD_W-1:0];

endmodule

FILE: rtl/fpbs_back.sv
// back end: task table, run queue, frame walk, budget and dispatch sequencer
// depends on fpbs_pkg and fpbs_mod_unit
module fpbs_back #(
    parameter int MAX_ENTRIES = fpbs_pkg::MAX_ENTRIES_DEF,
    parameter int QUEUE_DEPTH = fpbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [fpbs_pkg::TIME_W-1:0] cfg_wr_data,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  fpbs_pkg::cmd_t              cmd,
    output logic                        res_valid,
    input  logic                        res_ready,
    output fpbs_pkg::result_t           res
);
    import fpbs_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QF_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_START,
        S_WALK_DIV,
        S_DISP,
        S_DISP_Q,
        S_DISP_W,
        S_RESULT
    } state_t;

    state_t                    state_reg;
    logic [TIME_W-1:0]         budget_cfg_reg;
    logic [FRAME_W-1:0]        frame_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          walk_reg;
    logic [QA_W-1:0]           head_reg;
    logic [QF_W-1:0]           fill_reg;
    logic [QF_W-1:0]           runs_reg;
    logic signed [BUDGET_W-1:0] budget_reg;
    logic                      active_reg;
    logic                      ovf_reg;
    kind_t                     kind_reg;
    logic [INDEX_W-1:0]        idx_reg;
    logic                      out_valid_reg;
    result_t                   out_reg;

    // memories
    logic [PERIOD_W+PHASE_W-1:0] pp_mem [MAX_ENTRIES];
    logic [TIME_W-1:0]           worst_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]            queue_mem [QUEUE_DEPTH];
    logic [PERIOD_W+PHASE_W-1:0] pp_rd_reg;
    logic [TIME_W-1:0]           worst_rd_reg;
    logic [IDX_W-1:0]            q_rd_reg;

    logic                  table_full;
    logic                  tab_we;
    logic                  pp_re;
    logic                  q_we;
    logic                  q_re;
    logic                  worst_re;
    logic                  div_start;
    logic                  div_done;
    logic [PERIOD_W-1:0]   div_rem;
    logic [FRAME_W:0]      div_sum;
    logic [QF_W:0]         tail_sum;
    logic [QA_W-1:0]       tail;
    logic [QA_W-1:0]       head_inc;
    logic [BUDGET_W:0]     budget_diff;
    logic [BUDGET_W-1:0]   budget_sat;
    logic                  can_dispatch;
    logic                  budget_ok;
    logic                  out_free;
    logic                  out_load;

    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign cmd_ready  = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || res_ready;
    assign out_load   = (state_reg == S_RESULT) && out_free;

    // run queue tail and head wrap
    assign tail_sum = (QF_W+1)'(head_reg) + (QF_W+1)'(fill_reg);
    assign tail     = (tail_sum >= (QF_W+1)'(QUEUE_DEPTH))
                      ? QA_W'(tail_sum - (QF_W+1)'(QUEUE_DEPTH)) : QA_W'(tail_sum);
    assign head_inc = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QA_W'(1);

    // budget after a finished run, saturating at the bottom
    assign budget_diff = {budget_reg[BUDGET_W-1], budget_reg}
                         - {{(BUDGET_W-TIME_W+1){1'b0}}, cmd.operand};
    assign budget_sat  = (budget_diff[BUDGET_W] != budget_diff[BUDGET_W-1])
                         ? BUDGET_MIN : budget_diff[BUDGET_W-1:0];

    // dispatch conditions
    assign can_dispatch = active_reg && (runs_reg != '0) && (fill_reg != '0);
    assign budget_ok    = budget_reg > $signed({{(BUDGET_W-TIME_W){1'b0}}, worst_rd_reg});

    // frame + phase without wrap
    assign div_sum = {1'b0, frame_reg} + (FRAME_W+1)'(pp_rd_reg[PERIOD_W+PHASE_W-1:PERIOD_W]);

    // memory strobes
    assign tab_we    = (state_reg == S_IDLE) && cmd_valid && (cmd.op == OP_ADD) && !table_full;
    assign pp_re     = (state_reg == S_WALK_RD) && (walk_reg != count_reg);
    assign div_start = (state_reg == S_WALK_START) && (pp_rd_reg[PERIOD_W-1:0] != '0);
    assign q_we      = (state_reg == S_WALK_DIV) && div_done && (div_rem == '0)
                       && (fill_reg < QF_W'(QUEUE_DEPTH));
    assign q_re      = (state_reg == S_DISP) && can_dispatch;
    assign worst_re  = (state_reg == S_DISP_Q);

    fpbs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_sum),
        .divisor   (pp_rd_reg[PERIOD_W-1:0]),
        .done      (div_done),
        .remainder (div_rem)
    );

    // task table
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            pp_mem[IDX_W'(count_reg)]    <= {cmd.phase, cmd.period};
            worst_mem[IDX_W'(count_reg)] <= cmd.operand;
        end
        if (pp_re)
        begin
            pp_rd_reg <= pp_mem[IDX_W'(walk_reg)];
        end
        if (worst_re)
        begin
            worst_rd_reg <= worst_mem[q_rd_reg];
        end
    end

    // run queue
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[tail] <= IDX_W'(walk_reg);
        end
        if (q_re)
        begin
            q_rd_reg <= queue_mem[head_reg];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_cfg_reg <= FRAME_BUDGET_RESET;
        end
        else if (cfg_wr_en)
        begin
            budget_cfg_reg <= cfg_wr_data;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frame_reg     <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            runs_reg      <= '0;
            budget_reg    <= '0;
            active_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            kind_reg      <= KIND_FRAME_OVER;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // output register valid: set on load, cleared once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        ovf_reg <= 1'b0;
                        unique case (cmd.op)
                            OP_ADD:
                            begin
                                if (!table_full)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    kind_reg  <= KIND_ADDED;
                                    idx_reg   <= INDEX_W'(count_reg);
                                end
                                else
                                begin
                                    kind_reg <= KIND_REJECTED;
                                    idx_reg  <= '0;
                                end
                                state_reg <= S_RESULT;
                            end
                            OP_TICK:
                            begin
                                frame_reg <= frame_reg + FRAME_W'(1);
                                walk_reg  <= '0;
                                state_reg <= S_WALK_RD;
                            end
                            OP_DONE:
                            begin
                                if (active_reg)
                                begin
                                    budget_reg <= budget_sat;
                                    state_reg  <= S_DISP;
                                end
                                else
                                begin
                                    kind_reg  <= KIND_FRAME_OVER;
                                    idx_reg   <= '0;
                                    state_reg <= S_RESULT;
                                end
                            end
                            default:
                            begin
                                kind_reg  <= KIND_FRAME_OVER;
                                idx_reg   <= '0;
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                // step through the table, one entry per remainder
                S_WALK_RD:
                begin
                    if (walk_reg == count_reg)
                    begin
                        budget_reg <= $signed({{(BUDGET_W-TIME_W){1'b0}}, budget_cfg_reg});
                        runs_reg   <= fill_reg;
                        active_reg <= 1'b1;
                        state_reg  <= S_DISP;
                    end
                    else
                    begin
                        state_reg <= S_WALK_START;
                    end
                end
                S_WALK_START:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_WALK_DIV;
                    end
                    else
                    begin
                        // period zero: never due
                        walk_reg  <= walk_reg + CNT_W'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_rem == '0)
                        begin
                            if (q_we)
                            begin
                                fill_reg <= fill_reg + QF_W'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        walk_reg  <= walk_reg + CNT_W'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                // try the front of the run queue
                S_DISP:
                begin
                    if (can_dispatch)
                    begin
                        state_reg <= S_DISP_Q;
                    end
                    else
                    begin
                        active_reg <= 1'b0;
                        kind_reg   <= KIND_FRAME_OVER;
                        idx_reg    <= '0;
                        state_reg  <= S_RESULT;
                    end
                end
                S_DISP_Q:
                begin
                    state_reg <= S_DISP_W;
                end
                S_DISP_W:
                begin
                    if (budget_ok)
                    begin
                        head_reg <= head_inc;
                        fill_reg <= fill_reg - QF_W'(1);
                        runs_reg <= runs_reg - QF_W'(1);
                        kind_reg <= KIND_DISPATCH;
                        idx_reg  <= INDEX_W'(q_rd_reg);
                    end
                    else
                    begin
                        active_reg <= 1'b0;
                        kind_reg   <= KIND_FRAME_OVER;
                        idx_reg    <= '0;
                    end
                    state_reg <= S_RESULT;
                end
                // hand the result to the output register
                S_RESULT:
                begin
                    if (out_load)
                    begin
                        out_reg.kind          <= kind_reg;
                        out_reg.entry_index   <= idx_reg;
                        out_reg.queue_overflow <= ovf_reg;
                        out_reg.budget_left   <= budget_reg;
                        out_reg.pending_count <= PENDING_W'(fill_reg);
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: rtl/frequency_phase_budget_scheduler.sv
// top level of the frequency/phase budget scheduler: stream ports and packing
// depends on fpbs_pkg, fpbs_front and fpbs_back
//
// Each input item gives exactly one result item. Items are taken one at a time
// by a sequencer behind a two-entry command queue, so the input side keeps
// accepting until that queue is full while a result waits on the output. A
// run-done inside a frame goes through budget update, run queue read,
// worst-time read and compare, and skips the reads and the compare when nothing
// is left to run. A frame tick walks every table entry, then closes the frame
// at once or tries a dispatch: each entry with a nonzero period is checked by a
// bit-serial remainder unit on (frame + phase) mod period, an entry with period
// zero is skipped. Table and run queue are memories without reset; only entries
// that were written are ever read. The frame budget register may be written at
// any time the block is idle.
module frequency_phase_budget_scheduler #(
    parameter int MAX_ENTRIES = fpbs_pkg::MAX_ENTRIES_DEF,
    parameter int QUEUE_DEPTH = fpbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fpbs_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // period, phase_offset, worst_time_ns, elapsed_ns
    input  logic [fpbs_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [fpbs_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // entry_index, queue_overflow, budget_left, pending_count, zero fill
    output logic [fpbs_pkg::M_TDATA_W-1:0] m_tdata,
    // kind
    output logic [fpbs_pkg::KIND_W-1:0]    m_tuser
);
    import fpbs_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    result_t res;

    fpbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fpbs_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // pack the result fields, lowest first
    assign m_tdata = {5'd0, res.pending_count, res.budget_left,
                      res.queue_overflow, res.entry_index};
    assign m_tuser = res.kind;

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the frequency/phase budget scheduler
// holds its own model of the task table, run queue and frame budget
// depends on fpbs_pkg and frequency_phase_budget_scheduler
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpbs_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int RUNQ_SLOTS = 32;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam longint BUDGET_FLOOR = longint'($signed(BUDGET_MIN));

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [TIME_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACTION_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;

    // scheduler model state
    logic [TIME_W-1:0]   frame_budget_cfg;
    logic [FRAME_W-1:0]  frame_cnt;
    int unsigned         table_count;
    logic [PERIOD_W-1:0] tab_period [TABLE_SLOTS];
    logic [PHASE_W-1:0]  tab_phase [TABLE_SLOTS];
    logic [TIME_W-1:0]   tab_worst [TABLE_SLOTS];
    logic [INDEX_W-1:0]  ready_queue [RUNQ_SLOTS];
    int unsigned         rq_head;
    int unsigned         rq_fill;
    int unsigned         dispatches_left;
    longint              budget_now;
    bit                  in_frame;

    result_t     expected_results [$];
    int unsigned fail_count;
    int unsigned burst_left;
    int unsigned quiet_cycles;
    int unsigned rx_mode;
    int unsigned rx_mode_left;

    frequency_phase_budget_scheduler u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    always #4 clk = ~clk;

    // result item as the block reports it from the current model state
    function automatic result_t make_result(kind_t k, logic [INDEX_W-1:0] idx, logic ovf);
        result_t r;
        r.kind           = k;
        r.entry_index    = idx;
        r.queue_overflow = ovf;
        r.budget_left    = budget_now[BUDGET_W-1:0];
        r.pending_count  = PENDING_W'(rq_fill);
        return r;
    endfunction

    // dispatch the front task if the budget allows, else close the frame
    function automatic result_t dispatch_or_close(logic ovf);
        logic [INDEX_W-1:0] idx;
        if (in_frame && dispatches_left > 0 && rq_fill > 0) begin
            idx = ready_queue[rq_head];
            if (budget_now > longint'({32'd0, tab_worst[idx]})) begin
                rq_head = (rq_head + 1) % RUNQ_SLOTS;
                rq_fill--;
                dispatches_left--;
                return make_result(KIND_DISPATCH, idx, ovf);
            end
        end
        in_frame = 1'b0;
        return make_result(KIND_FRAME_OVER, '0, ovf);
    endfunction

    // advance the scheduler model by one item and return its result
    function automatic result_t predict_schedule(logic [ACTION_W-1:0] act,
                                                 logic [S_TDATA_W-1:0] data);
        logic [FRAME_W:0]   due_sum;
        logic [INDEX_W-1:0] slot;
        logic               ovf;
        int                 i;
        ovf = 1'b0;
        case (act)
            ACT_ADD:
            begin
                if (table_count >= TABLE_SLOTS)
                    return make_result(KIND_REJECTED, '0, 1'b0);
                slot = INDEX_W'(table_count);
                tab_period[slot] = data[15:0];
                tab_phase[slot]  = data[31:16];
                tab_worst[slot]  = data[63:32];
                table_count++;
                return make_result(KIND_ADDED, slot, 1'b0);
            end
            ACT_TICK:
            begin
                frame_cnt = frame_cnt + 1'b1;
                // queue due tasks in table order, sum formed without wrapping
                for (i = 0; i < table_count; i++)
                begin
                    due_sum = {1'b0, frame_cnt} + {17'd0, tab_phase[i]};
                    if (tab_period[i] != '0 && (due_sum % {17'd0, tab_period[i]}) == '0)
                    begin
                        if (rq_fill < RUNQ_SLOTS)
                        begin
                            ready_queue[(rq_head + rq_fill) % RUNQ_SLOTS] = INDEX_W'(i);
                            rq_fill++;
                        end
                        else
                            ovf = 1'b1;
                    end
                end
                budget_now      = longint'({32'd0, frame_budget_cfg});
                dispatches_left = rq_fill;
                in_frame        = 1'b1;
                return dispatch_or_close(ovf);
            end
            ACT_DONE:
            begin
                if (!in_frame)
                    return make_result(KIND_FRAME_OVER, '0, 1'b0);
                budget_now = budget_now - longint'({32'd0, data[95:64]});
                if (budget_now < BUDGET_FLOOR)
                    budget_now = BUDGET_FLOOR;
                return dispatch_or_close(1'b0);
            end
            default:
                return make_result(KIND_FRAME_OVER, '0, 1'b0);
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_payload();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // elapsed time mostly small against the budget, sometimes huge
    function automatic logic [TIME_W-1:0] pick_elapsed();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 5000);
        if (r < 8)
            return $urandom_range(0, 1500000);
        if (r == 8)
            return $urandom();
        return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    // send one item in bursts with random gaps, predict it on acceptance
    task automatic send_item(logic [ACTION_W-1:0] act, logic [S_TDATA_W-1:0] data);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.insert(expected_results.size(), predict_schedule(act, data));
        burst_left--;
    endtask

    // write the frame budget once every result is back
    task automatic write_frame_budget(logic [TIME_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        frame_budget_cfg = value;
        cfg_wr_en <= 1'b0;
    endtask

    // run-done and unused code outside a frame, tick on an empty table
    task automatic test_idle_actions();
        logic [S_TDATA_W-1:0] payload;
        payload = random_payload();
        payload[95:64] = '1;
        send_item(ACT_DONE, payload);
        send_item(ACT_UNUSED, random_payload());
        send_item(ACT_TICK, random_payload());
        payload[95:64] = '0;
        send_item(ACT_DONE, payload);
    endtask

    // fill the task table with extremes and mixed rates, then overfill it
    task automatic test_table_fill();
        logic [S_TDATA_W-1:0] payload;
        logic [PERIOD_W-1:0]  per;
        logic [PHASE_W-1:0]   pha;
        logic [TIME_W-1:0]    wst;
        int                   i;
        for (i = 0; i < TABLE_SLOTS + 2; i++)
        begin
            per = PERIOD_W'($urandom_range(1, 8));
            pha = PHASE_W'($urandom());
            wst = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5000) : $urandom_range(0, 3400000);
            case (i)
                0:  begin per = 16'd1;     pha = 16'd0;     wst = 32'd0;       end
                // period zero is never due
                1:  begin per = 16'd0;     pha = '1;        wst = '1;          end
                2:  begin per = 16'd2;     pha = 16'd1;     wst = 32'd1000;    end
                // longest period, due on the second tick only
                3:  begin per = '1;        pha = 16'd65533; wst = 32'd3000000; end
                4:  begin per = 16'd3;     pha = 16'd2;     wst = 32'd2500;    end
                5:  begin per = 16'd4;     pha = 16'd0;     wst = 32'd4000;    end
                6:  begin per = 16'd1;     pha = 16'h8000;  wst = 32'd100;     end
                16: begin per = '1;        pha = '1;        wst = '1;          end
                17: begin per = '0;        pha = '0;        wst = '0;          end
                default: ;
            endcase
            payload = random_payload();
            payload[15:0]  = per;
            payload[31:16] = pha;
            payload[63:32] = wst;
            send_item(ACT_ADD, payload);
        end
        // one frame with the reset budget
        send_item(ACT_TICK, random_payload());
        payload = random_payload();
        payload[95:64] = 32'd600000;
        send_item(ACT_DONE, payload);
    endtask

    // frames with random run-done traffic and some noise under one budget
    task automatic run_budget_phase(logic [TIME_W-1:0] budget, int unsigned item_total);
        logic [S_TDATA_W-1:0] payload;
        int unsigned          sent;
        int unsigned          pick;
        write_frame_budget(budget);
        sent = 0;
        while (sent < item_total)
        begin
            send_item(ACT_TICK, random_payload());
            sent++;
            while (in_frame && sent < item_total)
            begin
                pick = $urandom_range(0, 99);
                payload = random_payload();
                payload[95:64] = pick_elapsed();
                if (pick < 86)
                    send_item(ACT_DONE, payload);
                else if (pick < 91)
                    send_item(ACT_TICK, payload);
                else if (pick < 95)
                    send_item(ACT_ADD, payload);
                else
                    send_item(ACT_UNUSED, payload);
                sent++;
            end
            // stray run-done after the frame closed
            if ($urandom_range(0, 3) == 0)
            begin
                payload = random_payload();
                payload[95:64] = pick_elapsed();
                send_item(ACT_DONE, payload);
                sent++;
            end
        end
    endtask

    // zero budget: nothing runs, the run queue fills and drops due tasks
    task automatic test_queue_overflow();
        run_budget_phase('0, 120);
    endtask

    // reset, small, largest, mid-range and random budgets
    task automatic test_budget_sweep();
        run_budget_phase(32'd3500000, 300);
        run_budget_phase(32'd5000, 200);
        run_budget_phase('1, 250);
        run_budget_phase(32'd2000000, 250);
        run_budget_phase($urandom_range(1000, 4000000), 200);
    endtask

    task automatic report_mismatch(string field, logic [BUDGET_W-1:0] want,
                                   logic [BUDGET_W-1:0] got);
        $display("%0t mismatch %s expected %0h actual %0h", $realtime, field, want, got);
        fail_count++;
    endtask

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result expected none actual kind %0d data %0h",
                         $realtime, m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", want.kind, m_tuser);
                if (m_tdata[3:0] !== want.entry_index)
                    report_mismatch("entry_index", want.entry_index, m_tdata[3:0]);
                if (m_tdata[4] !== want.queue_overflow)
                    report_mismatch("queue_overflow", want.queue_overflow, m_tdata[4]);
                if (m_tdata[44:5] !== want.budget_left)
                    report_mismatch("budget_left", want.budget_left, m_tdata[44:5]);
                if (m_tdata[50:45] !== want.pending_count)
                    report_mismatch("pending_count", want.pending_count, m_tdata[50:45]);
            end
        end
    end

    // receiver stalls, switching between patterns
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 400);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_mode_left % 40) >= 30);
        endcase
    end

    // cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAIL frequency_phase_budget_scheduler");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_ADD;
        burst_left = 0;

        // model reset state
        frame_budget_cfg = FRAME_BUDGET_RESET;
        frame_cnt = '0;
        table_count = 0;
        rq_head = 0;
        rq_fill = 0;
        dispatches_left = 0;
        budget_now = 0;
        in_frame = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_actions();
        test_table_fill();
        test_queue_overflow();
        test_budget_sweep();

        // drain outstanding results
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS frequency_phase_budget_scheduler");
        else
            $display("FAIL frequency_phase_budget_scheduler");
        $finish;
    end

endmodule

FILE: files.f
rtl/fpbs_pkg.sv
rtl/fpbs_front.sv
rtl/fpbs_mod_unit.sv
rtl/fpbs_back.sv
rtl/frequency_phase_budget_scheduler.sv
tb/tb_top.sv
